@@ design/epvf_pkg.sv @@
package epvf_pkg;

  // Field widths fixed by the stream format
  localparam int VTX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int ACC_W  = 48;
  localparam int MODE_W = 2;

  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 144;
  localparam int PV_W       = 6 * VAL_W;
  localparam int FRC_W      = 3 * ACC_W;

  localparam int NUM_VERTICES_DEF = 1024;
  localparam logic [VAL_W-1:0] GAIN_RESET = 32'h0001_0000;

  // Item kinds carried on tuser
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PV_A,
    S_PV_B,
    S_DIFF,
    S_MAX,
    S_NORM,
    S_SQ_MUL,
    S_SQ_ACC,
    S_SQRT,
    S_DIV,
    S_DOT_MUL,
    S_DOT_ACC,
    S_ABS,
    S_K_HI,
    S_K_LO,
    S_K_ACC,
    S_F_HI,
    S_F_LO,
    S_F_ACC,
    S_FA_RD,
    S_FA_WR,
    S_FB_WR,
    S_RD,
    S_RD_OUT
  } state_t;

endpackage

@@ design/epvf_ram.sv @@
module epvf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/edge_pairwise_viscous_force.sv @@
// Channel | Ports       | tuser     | tdata (lowest bit first)
// --------+-------------+-----------+-----------------------------------------------
// in      | in_t*       | mode [1:0]| vertex_a, vertex_b, pos_x/y/z, vel_x/y/z, 4'b0
// out     | out_t*      | -         | force_x, force_y, force_z
// cfg     | cfg_we/wdata| -         | viscosity_gain
//
// A load word is written in the cycle it is accepted; a read word passes RD and
// RD_OUT, waiting in RD_OUT while the output is stalled. An edge word's length is
// set by the one shared 34x31 multiplier and the bit-serial square root and the
// divider, one divide per component; normalising shifts one bit per cycle. A
// zero-length edge ends after normalising. in_tready is high only while the
// sequencer is idle. Reset (rst_n low, synchronous) clears the sequencer and
// output valid, sets the gain to GAIN_RESET; vertex stores start undefined.
module edge_pairwise_viscous_force #(
  parameter int NUM_VERTICES = epvf_pkg::NUM_VERTICES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // vertex_a[9:0], vertex_b[19:10], pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, pad
  input  logic [epvf_pkg::IN_DATA_W-1:0]        in_tdata,
  // mode[1:0]
  input  logic [epvf_pkg::MODE_W-1:0]           in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // force_x[47:0], force_y[95:48], force_z[143:96]
  output logic [epvf_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  logic                                  cfg_we,
  input  logic [epvf_pkg::VAL_W-1:0]            cfg_wdata
);
  import epvf_pkg::*;

  localparam int ADDR_W = $clog2(NUM_VERTICES);
  localparam int IDX_W  = (ADDR_W > VTX_W) ? ADDR_W : VTX_W;

  localparam logic signed [56:0] ACC_MAX = 57'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [56:0] ACC_MIN = -ACC_MAX - 57'sd1;

  // Saturating add of a signed force term into a 48-bit accumulator
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic signed [55:0] f);
    logic signed [56:0] s;
    s = 57'(signed'(acc)) + 57'(f);
    if (s > ACC_MAX) begin
      return ACC_MAX[ACC_W-1:0];
    end else if (s < ACC_MIN) begin
      return ACC_MIN[ACC_W-1:0];
    end
    return s[ACC_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [VAL_W-1:0] gain_r;

  // Latched word
  logic [VTX_W-1:0] a_r, b_r;
  logic             a_ok_r;

  // Edge datapath
  logic [PV_W-1:0]   pva_r;
  logic [32:0]       dm_r [3];
  logic              dn_r [3];
  logic [32:0]       dvm_r [3];
  logic              dvn_r [3];
  logic [32:0]       m_r;
  logic [61:0]       n2_r;
  logic [61:0]       sq_n_r;
  logic [34:0]       sq_rem_r;
  logic [30:0]       sq_root_r;
  logic [31:0]       div_rem_r;
  logic [30:0]       div_q_r;
  logic [30:0]       e_r [3];
  logic signed [35:0] dot_r;
  logic [33:0]       dotm_r;
  logic              dot_neg_r;
  logic [51:0]       cm_r;
  logic [54:0]       fm_r;
  logic signed [55:0] f_r [3];
  logic [1:0]        idx_r;
  logic [4:0]        cnt_r;

  // Shared multiplier
  logic [33:0] mul_a;
  logic [30:0] mul_b;
  logic [64:0] prod_r;

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Memories
  logic              pv_we;
  logic [ADDR_W-1:0] pv_waddr, pv_raddr;
  logic [PV_W-1:0]   pv_rdata;
  logic              fr_we;
  logic [ADDR_W-1:0] fr_waddr, fr_raddr;
  logic [FRC_W-1:0]  fr_wdata, fr_rdata;

  // Handshake and address helpers
  logic              in_acc;
  logic [IDX_W-1:0]  in_a_ext, a_ext, b_ext;
  logic              in_a_ok, in_b_ok;
  logic [ADDR_W-1:0] in_a_addr, a_addr, b_addr;
  logic              out_free;

  // Combinational datapath terms
  logic signed [32:0] d_w [3];
  logic signed [32:0] dv_w [3];
  logic [32:0]        max_w;
  logic [61:0]        n2_sum;
  logic [34:0]        sq_t, sq_trial;
  logic               sq_ge;
  logic [31:0]        div_t;
  logic               div_ge;
  logic [30:0]        div_q_nxt;
  logic [34:0]        dot_term;
  logic [54:0]        fm_sum;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign in_a_ext  = IDX_W'(in_tdata[VTX_W-1:0]);
  assign a_ext     = IDX_W'(a_r);
  assign b_ext     = IDX_W'(b_r);
  assign in_a_addr = in_a_ext[ADDR_W-1:0];
  assign a_addr    = a_ext[ADDR_W-1:0];
  assign b_addr    = b_ext[ADDR_W-1:0];
  assign in_a_ok   = (32'(in_tdata[VTX_W-1:0]) < 32'(NUM_VERTICES));
  assign in_b_ok   = (32'(in_tdata[2*VTX_W-1:VTX_W]) < 32'(NUM_VERTICES));

  // Position and velocity store: pos_x/y/z then vel_x/y/z, lowest first
  epvf_ram #(.WIDTH(PV_W), .DEPTH(NUM_VERTICES)) u_pv_ram (
    .clk  (clk),
    .we   (pv_we),
    .waddr(pv_waddr),
    .wdata(in_tdata[2*VTX_W +: PV_W]),
    .raddr(pv_raddr),
    .rdata(pv_rdata)
  );

  // Force accumulators: x, y, z, lowest first
  epvf_ram #(.WIDTH(FRC_W), .DEPTH(NUM_VERTICES)) u_fr_ram (
    .clk  (clk),
    .we   (fr_we),
    .waddr(fr_waddr),
    .wdata(fr_wdata),
    .raddr(fr_raddr),
    .rdata(fr_rdata)
  );

  // Differences of a (held) and b (arriving from the store)
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d_w[c]  = 33'(signed'(pva_r[c*VAL_W +: VAL_W]))
              - 33'(signed'(pv_rdata[c*VAL_W +: VAL_W]));
      dv_w[c] = 33'(signed'(pva_r[(c+3)*VAL_W +: VAL_W]))
              - 33'(signed'(pv_rdata[(c+3)*VAL_W +: VAL_W]));
    end
  end

  always_comb begin
    max_w = dm_r[0];
    if (dm_r[1] > max_w) begin
      max_w = dm_r[1];
    end
    if (dm_r[2] > max_w) begin
      max_w = dm_r[2];
    end
  end

  assign n2_sum = n2_r + prod_r[61:0];

  // One root bit per cycle
  assign sq_t     = {sq_rem_r[32:0], sq_n_r[61:60]};
  assign sq_trial = 35'({sq_root_r, 2'b01});
  assign sq_ge    = (sq_t >= sq_trial);

  // One quotient bit per cycle; the first step takes the magnitude unshifted
  assign div_t     = (cnt_r == 5'd30) ? 32'(dm_r[idx_r]) : {div_rem_r[30:0], 1'b0};
  assign div_ge    = (div_t >= {1'b0, sq_root_r});
  assign div_q_nxt = {div_q_r[29:0], div_ge};

  assign dot_term = prod_r[64:30];
  assign fm_sum   = fm_r + 55'(prod_r[64:30]);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            MODE_EDGE: state_nxt = (in_a_ok && in_b_ok) ? S_PV_A : S_IDLE;
            MODE_READ: state_nxt = S_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_PV_A:    state_nxt = S_PV_B;
      S_PV_B:    state_nxt = S_DIFF;
      S_DIFF:    state_nxt = S_MAX;
      S_MAX:     state_nxt = S_NORM;
      S_NORM: begin
        if (m_r == 33'd0) begin
          state_nxt = S_IDLE;
        end else if (m_r[32:30] == 3'd0 && m_r[29]) begin
          state_nxt = S_SQ_MUL;
        end
      end
      S_SQ_MUL:  state_nxt = S_SQ_ACC;
      S_SQ_ACC:  state_nxt = (idx_r == 2'd2) ? S_SQRT : S_SQ_MUL;
      S_SQRT:    state_nxt = (cnt_r == 5'd0) ? S_DIV : S_SQRT;
      S_DIV:     state_nxt = (cnt_r == 5'd0 && idx_r == 2'd2) ? S_DOT_MUL : S_DIV;
      S_DOT_MUL: state_nxt = S_DOT_ACC;
      S_DOT_ACC: state_nxt = (idx_r == 2'd2) ? S_ABS : S_DOT_MUL;
      S_ABS:     state_nxt = S_K_HI;
      S_K_HI:    state_nxt = S_K_LO;
      S_K_LO:    state_nxt = S_K_ACC;
      S_K_ACC:   state_nxt = S_F_HI;
      S_F_HI:    state_nxt = S_F_LO;
      S_F_LO:    state_nxt = S_F_ACC;
      S_F_ACC:   state_nxt = (idx_r == 2'd2) ? S_FA_RD : S_F_HI;
      S_FA_RD:   state_nxt = S_FA_WR;
      S_FA_WR:   state_nxt = S_FB_WR;
      S_FB_WR:   state_nxt = S_IDLE;
      S_RD:      state_nxt = S_RD_OUT;
      S_RD_OUT:  state_nxt = out_free ? S_IDLE : S_RD_OUT;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Memory controls and multiplier operands
  always_comb begin
    pv_we    = 1'b0;
    pv_waddr = in_a_addr;
    pv_raddr = (state_r == S_PV_B) ? b_addr : a_addr;
    fr_we    = 1'b0;
    fr_waddr = a_addr;
    fr_wdata = '0;
    fr_raddr = (state_r == S_FA_WR) ? b_addr : a_addr;
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      S_IDLE: begin
        // On a load, store the vertex and clear its force in the same cycle
        if (in_acc && in_tuser == MODE_LOAD && in_a_ok) begin
          pv_we    = 1'b1;
          fr_we    = 1'b1;
          fr_waddr = in_a_addr;
        end
      end
      S_SQ_MUL: begin
        mul_a = 34'(dm_r[idx_r]);
        mul_b = dm_r[idx_r][30:0];
      end
      S_DOT_MUL: begin
        mul_a = 34'(dvm_r[idx_r]);
        mul_b = e_r[idx_r];
      end
      S_K_HI: begin
        mul_a = dotm_r;
        mul_b = 31'(gain_r[31:16]);
      end
      S_K_LO: begin
        mul_a = dotm_r;
        mul_b = 31'(gain_r[15:0]);
      end
      S_F_HI: begin
        mul_a = 34'(cm_r[51:30]);
        mul_b = e_r[idx_r];
      end
      S_F_LO: begin
        mul_a = 34'(cm_r[29:0]);
        mul_b = e_r[idx_r];
      end
      S_FA_WR: begin
        fr_we    = 1'b1;
        fr_waddr = a_addr;
        for (int c = 0; c < 3; c++) begin
          fr_wdata[c*ACC_W +: ACC_W] = sat_add(fr_rdata[c*ACC_W +: ACC_W], f_r[c]);
        end
      end
      S_FB_WR: begin
        fr_we    = 1'b1;
        fr_waddr = b_addr;
        for (int c = 0; c < 3; c++) begin
          fr_wdata[c*ACC_W +: ACC_W] = sat_add(fr_rdata[c*ACC_W +: ACC_W], -f_r[c]);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
      if (state_r == S_RD_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word: a vertex outside the store reads as zero force
  always_ff @(posedge clk) begin
    if (state_r == S_RD_OUT && out_free) begin
      out_data_r <= a_ok_r ? fr_rdata : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Datapath
  always_ff @(posedge clk) begin
    prod_r <= 65'(mul_a) * 65'(mul_b);
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          a_r    <= in_tdata[VTX_W-1:0];
          b_r    <= in_tdata[2*VTX_W-1:VTX_W];
          a_ok_r <= in_a_ok;
        end
      end
      S_PV_B: begin
        pva_r <= pv_rdata;
      end
      S_DIFF: begin
        for (int c = 0; c < 3; c++) begin
          dn_r[c]  <= d_w[c][32];
          dm_r[c]  <= d_w[c][32] ? 33'(-d_w[c]) : 33'(d_w[c]);
          dvn_r[c] <= dv_w[c][32];
          dvm_r[c] <= dv_w[c][32] ? 33'(-dv_w[c]) : 33'(dv_w[c]);
        end
      end
      S_MAX: begin
        m_r <= max_w;
      end
      S_NORM: begin
        // Bring the largest magnitude into [2^29, 2^30), one bit a cycle
        if (m_r[32:30] != 3'd0) begin
          m_r <= m_r >> 1;
          for (int c = 0; c < 3; c++) begin
            dm_r[c] <= dm_r[c] >> 1;
          end
        end else if (!m_r[29]) begin
          m_r <= m_r << 1;
          for (int c = 0; c < 3; c++) begin
            dm_r[c] <= dm_r[c] << 1;
          end
        end
        idx_r <= 2'd0;
        n2_r  <= '0;
      end
      S_SQ_ACC: begin
        n2_r      <= n2_sum;
        idx_r     <= idx_r + 2'd1;
        sq_n_r    <= n2_sum;
        sq_rem_r  <= '0;
        sq_root_r <= '0;
        cnt_r     <= 5'd30;
      end
      S_SQRT: begin
        sq_n_r    <= sq_n_r << 2;
        sq_rem_r  <= sq_ge ? (sq_t - sq_trial) : sq_t;
        sq_root_r <= {sq_root_r[29:0], sq_ge};
        if (cnt_r == 5'd0) begin
          cnt_r <= 5'd30;
          idx_r <= 2'd0;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
      S_DIV: begin
        div_rem_r <= div_ge ? (div_t - {1'b0, sq_root_r}) : div_t;
        div_q_r   <= div_q_nxt;
        if (cnt_r == 5'd0) begin
          e_r[idx_r] <= div_q_nxt;
          cnt_r      <= 5'd30;
          idx_r      <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
          dot_r      <= '0;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
      S_DOT_ACC: begin
        if (dvn_r[idx_r] != dn_r[idx_r]) begin
          dot_r <= dot_r - 36'(signed'({1'b0, dot_term}));
        end else begin
          dot_r <= dot_r + 36'(signed'({1'b0, dot_term}));
        end
        idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
      end
      S_ABS: begin
        dot_neg_r <= dot_r[35];
        dotm_r    <= dot_r[35] ? 34'(-dot_r) : dot_r[33:0];
      end
      S_K_LO: begin
        cm_r <= prod_r[51:0];
      end
      S_K_ACC: begin
        cm_r  <= cm_r + 52'(prod_r[64:16]);
        idx_r <= 2'd0;
      end
      S_F_LO: begin
        fm_r <= prod_r[54:0];
      end
      S_F_ACC: begin
        f_r[idx_r] <= (dot_neg_r != dn_r[idx_r]) ? -56'(signed'({1'b0, fm_sum}))
                                                  : 56'(signed'({1'b0, fm_sum}));
        idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ dv/tb_edge_pairwise_viscous_force.sv @@
module tb_edge_pairwise_viscous_force;
  timeunit 1ns;
  timeprecision 1ps;
  import epvf_pkg::*;

  // Mode 3 carries no meaning; the block must swallow it without trace
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int NV = NUM_VERTICES_DEF;
  // Settle long enough for a trailing edge word to finish
  localparam int SETTLE_CYCLES = 250;
  localparam int STALL_LIMIT = 6000;
  localparam int LONG_HOLD = 800;
  localparam longint unsigned LOW30 = 64'h3FFF_FFFF;
  localparam longint ACC_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_BOT = -ACC_TOP - 1;

  typedef struct {
    logic [ACC_W-1:0] fx;
    logic [ACC_W-1:0] fy;
    logic [ACC_W-1:0] fz;
  } force_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // vertex_a, vertex_b, pos_x/y/z, vel_x/y/z, pad
  logic [MODE_W-1:0]     in_tuser;   // mode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // force_x, force_y, force_z
  logic                  cfg_we;
  logic [VAL_W-1:0]      cfg_wdata;

  edge_pairwise_viscous_force dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block: vertex stores, force accumulators and the gain
  longint           shadow_pos [NV][3];
  longint           shadow_vel [NV][3];
  longint           shadow_frc [NV][3];
  bit               vtx_loaded [NV];
  int               loaded_list[$];
  logic [VAL_W-1:0] shadow_gain;

  force_t pending_forces[$];

  int  err_count;
  int  n_words, n_loads, n_edges, n_reads, n_spare, n_results, n_sat, n_gains;
  bit  no_gaps;        // run the sender back to back
  bit  hold_request;   // ask the receiver for one long hold-off
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort when nothing moves on either side for far too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("tb_edge_pairwise_viscous_force: done, errors");
        $finish;
      end
    end
  end

  function automatic longint unsigned magnitude(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint with_sign(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, bv;
    r  = 0;
    bv = 64'h4000_0000_0000_0000;
    while (bv > n) bv >>= 2;
    while (bv != 0) begin
      if (n >= r + bv) begin
        n -= r + bv;
        r = (r >> 1) + bv;
      end else begin
        r >>= 1;
      end
      bv >>= 2;
    end
    return r;
  endfunction

  function automatic longint clamp_acc(longint acc, longint f);
    longint s;
    s = acc + f;
    if (s > ACC_TOP) begin
      n_sat++;
      return ACC_TOP;
    end
    if (s < ACC_BOT) begin
      n_sat++;
      return ACC_BOT;
    end
    return s;
  endfunction

  // Dashpot force along the edge a-b, added to a and taken from b
  function automatic void apply_dashpot(int a, int b);
    longint          dp[3], dvel[3];
    bit              dneg[3];
    longint unsigned dm[3], unit[3], mx, n2, len, cm, fm, kh, kl;
    longint          dot, f;
    int              rs, ls;
    mx  = 0;
    dot = 0;
    rs  = 0;
    ls  = 0;
    for (int c = 0; c < 3; c++) begin
      dp[c]   = shadow_pos[a][c] - shadow_pos[b][c];
      dvel[c] = shadow_vel[a][c] - shadow_vel[b][c];
      dm[c]   = magnitude(dp[c]);
      dneg[c] = dp[c] < 0;
      if (dm[c] > mx) mx = dm[c];
    end
    if (mx == 0) return;
    // Normalise so the largest component sits in [2^29, 2^30)
    while (mx >= 64'd1 << 30) begin
      mx >>= 1;
      rs++;
    end
    while (mx < 64'd1 << 29) begin
      mx <<= 1;
      ls++;
    end
    n2 = 0;
    for (int c = 0; c < 3; c++) begin
      dm[c] = (dm[c] >> rs) << ls;
      n2 += dm[c] * dm[c];
    end
    len = root_floor(n2);
    if (len == 0) return;
    for (int c = 0; c < 3; c++) begin
      unit[c] = (dm[c] << 30) / len;
      dot += with_sign((magnitude(dvel[c]) * unit[c]) >> 30, (dvel[c] < 0) != dneg[c]);
    end
    kh = shadow_gain >> 16;
    kl = shadow_gain & 32'hFFFF;
    cm = kh * magnitude(dot) + ((kl * magnitude(dot)) >> 16);
    for (int c = 0; c < 3; c++) begin
      fm = (cm >> 30) * unit[c] + (((cm & LOW30) * unit[c]) >> 30);
      f  = with_sign(fm, (dot < 0) != dneg[c]);
      shadow_frc[a][c] = clamp_acc(shadow_frc[a][c], f);
      shadow_frc[b][c] = clamp_acc(shadow_frc[b][c], -f);
    end
  endfunction

  // Advance the shadow by one accepted word
  function automatic void predict_word(logic [MODE_W-1:0] mode, int a, int b,
                                       logic [VAL_W-1:0] p[3], logic [VAL_W-1:0] v[3]);
    force_t exp_f;
    n_words++;
    case (mode)
      MODE_LOAD: begin
        n_loads++;
        for (int c = 0; c < 3; c++) begin
          shadow_pos[a][c] = longint'(signed'(p[c]));
          shadow_vel[a][c] = longint'(signed'(v[c]));
          shadow_frc[a][c] = 0;
        end
        if (!vtx_loaded[a]) loaded_list.push_back(a);
        vtx_loaded[a] = 1'b1;
      end
      MODE_EDGE: begin
        n_edges++;
        apply_dashpot(a, b);
      end
      MODE_READ: begin
        n_reads++;
        exp_f.fx = shadow_frc[a][0][ACC_W-1:0];
        exp_f.fy = shadow_frc[a][1][ACC_W-1:0];
        exp_f.fz = shadow_frc[a][2][ACC_W-1:0];
        pending_forces.push_back(exp_f);
      end
      default: n_spare++;
    endcase
  endfunction

  // Offer one word after a random gap, hold it until taken, then predict
  task automatic send_word(logic [MODE_W-1:0] mode, int a, int b,
                           logic [VAL_W-1:0] p[3], logic [VAL_W-1:0] v[3]);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {4'b0, v[2], v[1], v[0], p[2], p[1], p[0], b[VTX_W-1:0], a[VTX_W-1:0]};
    in_tuser  = mode;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_word(mode, a, b, p, v);
  endtask

  task automatic send_load(int a, logic [VAL_W-1:0] p[3], logic [VAL_W-1:0] v[3]);
    send_word(MODE_LOAD, a, 0, p, v);
  endtask

  task automatic send_ab(logic [MODE_W-1:0] mode, int a, int b);
    logic [VAL_W-1:0] junk_p[3], junk_v[3];
    // Fields that the mode ignores still carry random bits
    for (int c = 0; c < 3; c++) begin
      junk_p[c] = $urandom;
      junk_v[c] = $urandom;
    end
    send_word(mode, a, b, junk_p, junk_v);
  endtask

  // Drop valid, drain every result, let a trailing edge finish, then write K
  task automatic set_gain(logic [VAL_W-1:0] k);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = k;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = $urandom;
    shadow_gain = k;
    n_gains++;
  endtask

  // Value classes: full random, small, near-extreme and exact extremes
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return 32'(signed'($urandom_range(0, 2 ** 21)) - 2 ** 20);
      3:    return 32'(signed'($urandom_range(0, 2 ** 25)) - 2 ** 24);
      4:    return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 7)
                                        : 32'h8000_0000 + $urandom_range(0, 7);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  task automatic load_random(int a);
    logic [VAL_W-1:0] p[3], v[3];
    for (int c = 0; c < 3; c++) begin
      p[c] = pick_value();
      v[c] = pick_value();
    end
    send_load(a, p, v);
  endtask

  function automatic int any_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // Receiver: random back-pressure, one long hold-off on request, check in order
  initial begin
    int     w;
    force_t exp_f;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      w = no_gaps ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (w > 0) begin
        out_tready = 1'b0;
        repeat (w) @(negedge clk);
      end
      if (hold_request) begin
        out_tready = 1'b0;
        for (int i = 0; i < LONG_HOLD; i++) @(negedge clk);
        hold_request = 1'b0;
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      n_results++;
      if (pending_forces.size() == 0) begin
        $error("force word with nothing expected: %h", out_tdata);
        err_count++;
      end else begin
        exp_f = pending_forces.pop_front();
        if (out_tdata[ACC_W-1:0] !== exp_f.fx) begin
          $error("force_x expected %h got %h", exp_f.fx, out_tdata[ACC_W-1:0]);
          err_count++;
        end
        if (out_tdata[2*ACC_W-1:ACC_W] !== exp_f.fy) begin
          $error("force_y expected %h got %h", exp_f.fy, out_tdata[2*ACC_W-1:ACC_W]);
          err_count++;
        end
        if (out_tdata[3*ACC_W-1:2*ACC_W] !== exp_f.fz) begin
          $error("force_z expected %h got %h", exp_f.fz, out_tdata[3*ACC_W-1:2*ACC_W]);
          err_count++;
        end
      end
    end
  end

  // Extreme indices and field values, and a full-range edge between them
  task automatic test_extremes();
    logic [VAL_W-1:0] p[3], v[3];
    p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
    v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    send_load(0, p, v);
    p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
    send_load(NV - 1, p, v);
    send_ab(MODE_READ, 0, 0);
    send_ab(MODE_EDGE, 0, NV - 1);
    send_ab(MODE_EDGE, NV - 1, 0);
    send_ab(MODE_READ, 0, 0);
    send_ab(MODE_READ, NV - 1, 0);
  endtask

  // Same vertex twice, and two vertices at the same place: no contribution
  task automatic test_zero_length();
    logic [VAL_W-1:0] p[3], v[3];
    p = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
    v = '{32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000};
    send_load(341, p, v);
    v = '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF};
    send_load(682, p, v);
    send_ab(MODE_EDGE, 341, 341);
    send_ab(MODE_EDGE, 341, 682);
    send_ab(MODE_READ, 341, 0);
    send_ab(MODE_READ, 682, 0);
  endtask

  // Highest gain and opposite extremes drive both accumulators into the rails
  task automatic test_saturation();
    logic [VAL_W-1:0] p[3], v[3];
    set_gain(32'hFFFF_FFFF);
    p = '{32'h7FFF_FFFF, 32'h0, 32'h0};
    v = '{32'h7FFF_FFFF, 32'h0, 32'h0};
    send_load(5, p, v);
    p = '{32'h8000_0000, 32'h0, 32'h0};
    v = '{32'h8000_0000, 32'h0, 32'h0};
    send_load(6, p, v);
    repeat (2) send_ab(MODE_EDGE, 5, 6);
    send_ab(MODE_READ, 5, 0);
    send_ab(MODE_READ, 6, 0);
  endtask

  // The spare mode must change nothing and return nothing
  task automatic test_spare_mode();
    send_ab(MODE_SPARE, 5, 6);
    send_ab(MODE_SPARE, $urandom_range(0, NV - 1), $urandom_range(0, NV - 1));
    send_ab(MODE_READ, 5, 0);
  endtask

  // Mostly a small working set so edges hit the same accumulators often
  task automatic test_random(int n_items);
    int pool[32];
    int sel;
    foreach (pool[i]) pool[i] = $urandom_range(0, NV - 1);
    for (int i = 0; i < n_items; i++) begin
      if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 18 || loaded_list.size() < 2) begin
        load_random($urandom_range(0, 9) == 0 ? $urandom_range(0, NV - 1)
                                              : pool[$urandom_range(0, 31)]);
      end else if (sel < 68) begin
        send_ab(MODE_EDGE, any_loaded(), any_loaded());
      end else if (sel < 96) begin
        send_ab(MODE_READ, any_loaded(), $urandom_range(0, NV - 1));
      end else begin
        send_ab(MODE_SPARE, $urandom_range(0, NV - 1), $urandom_range(0, NV - 1));
      end
    end
    no_gaps = 1'b0;
  endtask

  // Hold the receiver off while reads keep coming, so the input stalls
  task automatic test_backpressure();
    hold_request = 1'b1;
    no_gaps = 1'b1;
    for (int i = 0; i < 16; i++) send_ab(MODE_READ, any_loaded(), 0);
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = MODE_LOAD;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    err_count    = 0;
    quiet_cycles = 0;
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    shadow_gain  = GAIN_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_zero_length();
    test_saturation();
    set_gain(GAIN_RESET);
    test_spare_mode();

    test_random(480);
    test_backpressure();
    set_gain(32'h0);
    test_random(300);
    set_gain($urandom);
    test_random(480);
    set_gain(32'hFFFF_FFFF);
    test_random(300);
    set_gain($urandom_range(1, 32'h0004_0000));
    test_random(360);

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d loads, %0d edges, %0d reads, %0d spare-mode",
             n_words, n_loads, n_edges, n_reads, n_spare);
    $display("%0d force words checked, %0d saturating sums, %0d gain settings",
             n_results, n_sat, n_gains);
    if (err_count == 0) begin
      $display("tb_edge_pairwise_viscous_force: done, clean");
    end else begin
      $display("tb_edge_pairwise_viscous_force: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/epvf_pkg.sv
design/epvf_ram.sv
design/edge_pairwise_viscous_force.sv
dv/tb_edge_pairwise_viscous_force.sv
